/* sv/dbsg_pkg.sv */
// Shared types, sizes and register codes for the diamond brush height grid.
package dbsg_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int MAX_RADIUS = 50;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Signed working width for row/column arithmetic around the stamp centre.
  localparam int COORD_W = 12;

  localparam int CELL_W = 16;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROWS    = 3'd0;
  localparam logic [2:0] REG_COLS    = 3'd1;
  localparam logic [2:0] REG_RADIUS  = 3'd2;
  localparam logic [2:0] REG_MAX_VAL = 3'd3;
  localparam logic [2:0] REG_MIN_VAL = 3'd4;

  localparam logic OP_STAMP = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic               op;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] strength;
  } in_t;

  typedef struct packed {
    logic signed [15:0] cell_value;
    logic               ignored;
  } out_t;

  typedef struct packed {
    logic [6:0]         rows_in_use;
    logic [6:0]         cols_in_use;
    logic [5:0]         radius;
    logic signed [15:0] max_value;
    logic signed [15:0] min_value;
  } cfg_t;

  // Memory access issued by the walker.
  typedef struct packed {
    logic               rd;
    logic               stamp;
    addr_t              addr;
    logic signed [15:0] strength;
  } acc_t;

  // Clearing-pass write.
  typedef struct packed {
    logic  en;
    addr_t addr;
  } clr_t;

  function automatic addr_t cell_addr(coord_t r, coord_t c);
    return addr_t'(int'(r) * MAX_COLS + int'(c));
  endfunction

endpackage

/* sv/dbsg_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port.
module dbsg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/dbsg_update.sv */
// Read-modify-write stage: saturating add of the stamp strength, and clearing writes.
module dbsg_update import dbsg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  acc_t               acc,
  input  clr_t               clr,
  input  logic signed [15:0] max_value,
  input  logic signed [15:0] min_value,
  input  logic [CELL_W-1:0]  rdata,
  output logic               we,
  output addr_t              waddr,
  output logic [CELL_W-1:0]  wdata
);

  logic               pend_r, pend_nxt;
  addr_t              pend_addr_r;
  logic signed [15:0] pend_str_r;
  logic signed [16:0] sum;
  logic signed [15:0] clamped;

  assign pend_nxt = acc.rd && acc.stamp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= acc.addr;
    pend_str_r  <= acc.strength;
  end

  // Full-width sum first, then the upper test wins over the lower one.
  always_comb begin
    sum = 17'(signed'(rdata)) + 17'(pend_str_r);
    if (sum > 17'(max_value)) begin
      clamped = max_value;
    end else if (sum < 17'(min_value)) begin
      clamped = min_value;
    end else begin
      clamped = sum[15:0];
    end
  end

  assign we    = clr.en || pend_r;
  assign waddr = clr.en ? clr.addr : pend_addr_r;
  assign wdata = clr.en ? '0 : clamped;

endmodule

/* sv/dbsg_walk.sv */
// Sequencer: clearing pass, diamond scan row by row, cell reads and result hold.
module dbsg_walk import dbsg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic [CELL_W-1:0] rdata,
  output acc_t              acc,
  output clr_t              clr
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RDWAIT = 3'd2;
  localparam logic [2:0] ST_SETUP  = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  logic [2:0]         state_r, state_nxt;
  addr_t              clr_cnt_r, clr_cnt_nxt;
  coord_t             ctr_row_r, ctr_row_nxt;
  coord_t             ctr_col_r, ctr_col_nxt;
  coord_t             rad_r, rad_nxt;
  coord_t             nc_r, nc_nxt;
  coord_t             r_cur_r, r_cur_nxt;
  coord_t             r_end_r, r_end_nxt;
  coord_t             c_cur_r, c_cur_nxt;
  coord_t             c_hi_r, c_hi_nxt;
  logic signed [15:0] str_r, str_nxt;
  out_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  coord_t nr, nc, rad, row_in, col_in;
  coord_t r_lo, r_hi, dr, adr, span, c_lo, c_hi;
  logic   outside;

  always_comb begin
    nr = coord_t'(cfg.rows_in_use);
    if (nr > coord_t'(MAX_ROWS)) begin
      nr = coord_t'(MAX_ROWS);
    end
    nc = coord_t'(cfg.cols_in_use);
    if (nc > coord_t'(MAX_COLS)) begin
      nc = coord_t'(MAX_COLS);
    end
    rad = coord_t'(cfg.radius);
    if (rad > coord_t'(MAX_RADIUS)) begin
      rad = coord_t'(MAX_RADIUS);
    end
    row_in  = coord_t'(in_data.row);
    col_in  = coord_t'(in_data.col);
    outside = (row_in >= nr) || (col_in >= nc);
    r_lo    = row_in - rad;
    if (r_lo < 0) begin
      r_lo = '0;
    end
    r_hi = row_in + rad;
    if (r_hi > nr - coord_t'(1)) begin
      r_hi = nr - coord_t'(1);
    end
    // Column span of the current row, clipped to the active columns.
    dr   = r_cur_r - ctr_row_r;
    adr  = (dr < 0) ? -dr : dr;
    span = rad_r - adr;
    c_lo = ctr_col_r - span;
    if (c_lo < 0) begin
      c_lo = '0;
    end
    c_hi = ctr_col_r + span;
    if (c_hi > nc_r - coord_t'(1)) begin
      c_hi = nc_r - coord_t'(1);
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    ctr_row_nxt   = ctr_row_r;
    ctr_col_nxt   = ctr_col_r;
    rad_nxt       = rad_r;
    nc_nxt        = nc_r;
    r_cur_nxt     = r_cur_r;
    r_end_nxt     = r_end_r;
    c_cur_nxt     = c_cur_r;
    c_hi_nxt      = c_hi_r;
    str_nxt       = str_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    acc.rd        = 1'b0;
    acc.stamp     = 1'b0;
    acc.addr      = cell_addr(r_cur_r, c_cur_r);
    acc.strength  = str_r;
    clr.en        = 1'b0;
    clr.addr      = clr_cnt_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        clr.en      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + addr_t'(1);
        if (clr_cnt_r == addr_t'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt.cell_value = '0;
          res_nxt.ignored    = outside;
          if (outside) begin
            state_nxt = ST_RESULT;
          end else if (in_data.op == OP_READ) begin
            acc.rd    = 1'b1;
            acc.addr  = cell_addr(row_in, col_in);
            state_nxt = ST_RDWAIT;
          end else begin
            ctr_row_nxt = row_in;
            ctr_col_nxt = col_in;
            rad_nxt     = rad;
            nc_nxt      = nc;
            r_cur_nxt   = r_lo;
            r_end_nxt   = r_hi;
            str_nxt     = in_data.strength;
            state_nxt   = ST_SETUP;
          end
        end
      end
      ST_RDWAIT: begin
        res_nxt.cell_value = signed'(rdata);
        state_nxt          = ST_RESULT;
      end
      ST_SETUP: begin
        c_cur_nxt = c_lo;
        c_hi_nxt  = c_hi;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        acc.rd    = 1'b1;
        acc.stamp = 1'b1;
        if (c_cur_r == c_hi_r) begin
          if (r_cur_r == r_end_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            r_cur_nxt = r_cur_r + coord_t'(1);
            state_nxt = ST_SETUP;
          end
        end else begin
          c_cur_nxt = c_cur_r + coord_t'(1);
        end
      end
      ST_DRAIN: begin
        // last cell is written back this cycle
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctr_row_r  <= ctr_row_nxt;
    ctr_col_r  <= ctr_col_nxt;
    rad_r      <= rad_nxt;
    nc_r       <= nc_nxt;
    r_cur_r    <= r_cur_nxt;
    r_end_r    <= r_end_nxt;
    c_cur_r    <= c_cur_nxt;
    c_hi_r     <= c_hi_nxt;
    str_r      <= str_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* sv/diamond_brush_saturating_grid.sv */
// Top level of the diamond brush height grid: config registers, sequencer, RMW stage, cell RAM.
//
//   channel | ports                          | transfer when
//   --------+--------------------------------+---------------------------
//   input   | in_valid, in_ready, in_data    | in_valid && in_ready
//   result  | out_valid, out_ready, out_data | out_valid && out_ready
//   config  | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// After reset the cell RAM is cleared one entry a cycle, all MAX_ROWS*MAX_COLS = 4096
// entries, with in_ready low; config writes are taken during that time.
// Read: RDWAIT takes the cell value, then RESULT posts it; an item outside the
// active grid goes straight to RESULT. Stamp: SETUP, then WALK over the row's cells, per
// row of the clipped diamond, then DRAIN and RESULT; the single read/write port pair of
// the cell RAM sets the one-cell-a-cycle pace in WALK. One item is in flight at a time;
// a result waits in the output register while the next item is accepted.
module diamond_brush_saturating_grid import dbsg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t              cfg_r, cfg_nxt;
  acc_t              acc;
  clr_t              clr;
  logic              we;
  addr_t             waddr;
  logic [CELL_W-1:0] wdata;
  logic [CELL_W-1:0] rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ROWS:    cfg_nxt.rows_in_use = cfg_wdata[6:0];
        REG_COLS:    cfg_nxt.cols_in_use = cfg_wdata[6:0];
        REG_RADIUS:  cfg_nxt.radius      = cfg_wdata[5:0];
        REG_MAX_VAL: cfg_nxt.max_value   = signed'(cfg_wdata);
        REG_MIN_VAL: cfg_nxt.min_value   = signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows_in_use <= 7'd64;
      cfg_r.cols_in_use <= 7'd64;
      cfg_r.radius      <= 6'd5;
      cfg_r.max_value   <= 16'sd100;
      cfg_r.min_value   <= 16'sd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dbsg_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .rdata     (rdata),
    .acc       (acc),
    .clr       (clr)
  );

  dbsg_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .clr       (clr),
    .max_value (cfg_r.max_value),
    .min_value (cfg_r.min_value),
    .rdata     (rdata),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata)
  );

  dbsg_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (acc.rd),
    .raddr (acc.addr),
    .rdata (rdata)
  );

endmodule

/* tb/sv/tb.sv */
// Testbench for the diamond brush height grid: queued driver, checking monitor, grid predictor.
module tb;
  import dbsg_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_CYCLES = 400;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = REG_ROWS;
  logic [15:0] cfg_wdata = '0;

  // Mirror of the grid and its registers
  logic signed [15:0] height_grid [0:MAX_ROWS*MAX_COLS-1];
  logic [6:0]         g_rows;
  logic [6:0]         g_cols;
  logic [5:0]         g_rad;
  logic signed [15:0] g_max;
  logic signed [15:0] g_min;

  in_t  brush_items [$];
  out_t cell_answers [$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int rx_epoch       = 0;
  logic [15:0] rx_pattern = 16'hFFFF;
  int last_row       = 0;
  int last_col       = 0;

  diamond_brush_saturating_grid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int clip_to(int v, int top);
    return (v > top) ? top : v;
  endfunction

  function automatic int jitter(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v;
  endfunction

  // Applies one item to the mirror grid and returns the result it should produce.
  function automatic out_t grid_step(in_t it);
    out_t res;
    int   nr, nc, rad, dr, r, c, span, sum;
    res = '0;
    nr  = clip_to(int'(g_rows), MAX_ROWS);
    nc  = clip_to(int'(g_cols), MAX_COLS);
    rad = clip_to(int'(g_rad), MAX_RADIUS);
    if (int'(it.row) >= nr || int'(it.col) >= nc) begin
      res.ignored = 1'b1;
    end else if (it.op == OP_READ) begin
      res.cell_value = height_grid[int'(it.row) * MAX_COLS + int'(it.col)];
    end else begin
      for (dr = -rad; dr <= rad; dr++) begin
        r    = int'(it.row) + dr;
        span = rad - ((dr < 0) ? -dr : dr);
        if (r >= 0 && r < nr) begin
          for (c = int'(it.col) - span; c <= int'(it.col) + span; c++) begin
            if (c >= 0 && c < nc) begin
              sum = int'(height_grid[r * MAX_COLS + c]) + int'(it.strength);
              // max is tested first, so an inverted pair still resolves
              if (sum > int'(g_max)) sum = int'(g_max);
              else if (sum < int'(g_min)) sum = int'(g_min);
              height_grid[r * MAX_COLS + c] = 16'(sum);
            end
          end
        end
      end
    end
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic void add_item(logic op, int row, int col, int strength);
    in_t it;
    it.op       = op;
    it.row      = 6'(row);
    it.col      = 6'(col);
    it.strength = 16'(strength);
    brush_items.push_back(it);
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ROWS:    g_rows = data[6:0];
      REG_COLS:    g_cols = data[6:0];
      REG_RADIUS:  g_rad  = data[5:0];
      REG_MAX_VAL: g_max  = data;
      REG_MIN_VAL: g_min  = data;
      default: ;
    endcase
  endtask

  // junk puts random bits above each narrow register's width
  task automatic write_grid_cfg(int rows, int cols, int rad, int maxv, int minv, bit junk);
    logic [15:0] hi;
    hi = junk ? 16'($urandom) : 16'h0000;
    cfg_write(REG_ROWS, (hi & 16'hFF80) | 16'(rows));
    hi = junk ? 16'($urandom) : 16'h0000;
    cfg_write(REG_COLS, (hi & 16'hFF80) | 16'(cols));
    hi = junk ? 16'($urandom) : 16'h0000;
    cfg_write(REG_RADIUS, (hi & 16'hFFC0) | 16'(rad));
    cfg_write(REG_MAX_VAL, 16'(maxv));
    cfg_write(REG_MIN_VAL, 16'(minv));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_until_quiet();
    @(negedge clk);
    while (brush_items.size() != 0 || in_valid || cell_answers.size() != 0) @(negedge clk);
  endtask

  function automatic void queue_random_items(int n);
    in_t it;
    int  k, nr, nc, pick;
    nr = clip_to(int'(g_rows), MAX_ROWS);
    nc = clip_to(int'(g_cols), MAX_COLS);
    for (k = 0; k < n; k++) begin
      it.op = ($urandom_range(0, 9) < 4) ? OP_READ : OP_STAMP;
      pick  = $urandom_range(0, 9);
      if (pick == 0 || nr == 0 || nc == 0) begin
        it.row = 6'($urandom);
        it.col = 6'($urandom);
      end else if (pick < 4) begin
        // land near the last stamp so reads see its edges
        it.row = 6'(jitter(last_row, int'(g_rad) + 1));
        it.col = 6'(jitter(last_col, int'(g_rad) + 1));
      end else begin
        it.row = 6'($urandom_range(0, nr - 1));
        it.col = 6'($urandom_range(0, nc - 1));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        case ($urandom_range(0, 4))
          0:       it.strength = 16'sh7FFF;
          1:       it.strength = 16'sh8000;
          2:       it.strength = 16'sh0000;
          3:       it.strength = -16'sd1;
          default: it.strength = 16'sd1;
        endcase
      end else if (pick < 4) begin
        it.strength = 16'($urandom);
      end else begin
        it.strength = 16'(int'($urandom_range(0, 400)) - 200);
      end
      if (it.op == OP_STAMP) begin
        last_row = int'(it.row);
        last_col = int'(it.col);
      end
      brush_items.push_back(it);
    end
  endfunction

  task automatic random_phase(bit wide);
    int rows, cols, rad, maxv, minv;
    case ($urandom_range(0, 5))
      0:       rows = 1;
      1:       rows = $urandom_range(65, 127);
      2:       rows = 64;
      default: rows = $urandom_range(1, 64);
    endcase
    case ($urandom_range(0, 5))
      0:       cols = 1;
      1:       cols = $urandom_range(65, 127);
      2:       cols = 64;
      default: cols = $urandom_range(1, 64);
    endcase
    if (wide) rad = $urandom_range(MAX_RADIUS, 63);
    else if ($urandom_range(0, 3) == 0) rad = $urandom_range(5, 10);
    else rad = $urandom_range(0, 4);
    case ($urandom_range(0, 5))
      0: begin
        maxv = 32767;
        minv = -32768;
      end
      1: begin
        maxv = int'($urandom_range(0, 200)) - 100;
        minv = maxv + int'($urandom_range(1, 100));
      end
      2: begin
        maxv = $urandom_range(0, 300);
        minv = -int'($urandom_range(0, 300));
      end
      3: begin
        maxv = -32768;
        minv = 32767;
      end
      default: begin
        maxv = int'($signed(16'($urandom)));
        minv = int'($signed(16'($urandom)));
      end
    endcase
    write_grid_cfg(rows, cols, rad, maxv, minv, 1'($urandom_range(0, 1)));
    queue_random_items(wide ? 10 : 130);
    wait_until_quiet();
  endtask

  // Sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) begin
        cell_answers.push_back(grid_step(in_data));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (brush_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= brush_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transfer, stalls on a rotating pattern
  always @(posedge clk) begin
    out_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (cell_answers.size() == 0) begin
          note_mismatch("result with nothing outstanding");
        end else begin
          due = cell_answers.pop_front();
          if (out_data.cell_value !== due.cell_value)
            note_mismatch($sformatf("cell_value %0d, predicted %0d",
                                    out_data.cell_value, due.cell_value));
          if (out_data.ignored !== due.ignored)
            note_mismatch($sformatf("ignored %0b, predicted %0b",
                                    out_data.ignored, due.ignored));
        end
        results_seen++;
        // one long hold-off so the block backs up and drops in_ready
        if (results_seen == HOLD_AT && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      rx_epoch++;
      if (rx_epoch % 128 == 0)
        rx_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      else
        rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rx_pattern[0];
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int ph;
    for (ph = 0; ph < MAX_ROWS * MAX_COLS; ph++) height_grid[ph] = '0;
    g_rows = 7'd64;
    g_cols = 7'd64;
    g_rad  = 6'd5;
    g_max  = 16'sd100;
    g_min  = 16'sd0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: corner clipping, clamping at both ends
    add_item(OP_READ,   0,  0,      0);
    add_item(OP_STAMP,  0,  0,     30);
    add_item(OP_READ,   0,  0,      0);
    add_item(OP_READ,   0,  5,      0);
    add_item(OP_READ,   3,  3,      0);
    add_item(OP_STAMP, 63, 63,  32767);
    add_item(OP_READ,  63, 63,      0);
    add_item(OP_STAMP, 32, 32, -32768);
    add_item(OP_STAMP, 40, 40,     -1);
    add_item(OP_READ,  32, 32,      0);
    wait_until_quiet();

    // small grid, zero radius, full clamp range; centres outside are ignored
    write_grid_cfg(10, 20, 0, 32767, -32768, 1'b1);
    add_item(OP_STAMP,  9, 19,   1000);
    add_item(OP_STAMP, 10,  0,      5);
    add_item(OP_READ,   0, 20,      0);
    add_item(OP_READ,  63, 63,      0);
    add_item(OP_READ,   9, 19,      0);
    add_item(OP_STAMP,  0,  0, -32768);
    add_item(OP_READ,   0,  0,      0);
    wait_until_quiet();

    // no rows in use
    write_grid_cfg(0, 64, 5, 100, 0, 1'b0);
    add_item(OP_STAMP, 0, 0, 7);
    add_item(OP_READ,  0, 0, 0);
    wait_until_quiet();

    // oversized registers, inverted clamp pair, hidden cells visible again
    write_grid_cfg(127, 100, 63, -100, 100, 1'b0);
    add_item(OP_READ,  63, 63, 0);
    add_item(OP_STAMP, 32, 32, 5);
    add_item(OP_READ,   0,  0, 0);
    add_item(OP_READ,  32, 32, 0);
    add_item(OP_READ,  63, 63, 0);
    wait_until_quiet();

    for (ph = 0; ph < 16; ph++) random_phase(ph % 5 == 4);

    wait_until_quiet();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
